// ===== hdl/dtnu_pkg.sv =====
// shared types and constants for the device-to-node table update block
package dtnu_pkg;

  parameter int unsigned TableEntries = 16;
  parameter int unsigned AddrWidth    = 32;
  parameter int unsigned NodeWidth    = 64;
  parameter int unsigned SlotWidth    = 4;

  typedef enum logic [1:0] {
    STATUS_UPDATED  = 2'd0,
    STATUS_INSERTED = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_WRITE = 2'd2
  } state_e;

  typedef struct packed {
    logic [AddrWidth-1:0] dev_address;
    logic [NodeWidth-1:0] node_ident;
  } req_t;

  typedef struct packed {
    status_e              result_status;
    logic [SlotWidth-1:0] slot_index;
  } rsp_t;

endpackage

// ===== hdl/dtnu_addr_mem.sv =====
// device address memory, one write port and one registered read port
module dtnu_addr_mem #(
  parameter int unsigned Depth    = dtnu_pkg::TableEntries,
  parameter int unsigned Width    = dtnu_pkg::AddrWidth,
  parameter int unsigned IdxWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxWidth-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [IdxWidth-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dtnu_node_mem.sv =====
// node identifier memory, written on update or insert
module dtnu_node_mem #(
  parameter int unsigned Depth    = dtnu_pkg::TableEntries,
  parameter int unsigned Width    = dtnu_pkg::NodeWidth,
  parameter int unsigned IdxWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxWidth-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule

// ===== hdl/dtnu_ctrl.sv =====
// sequencer: scans the address memory, tracks the lowest free slot, writes back
module dtnu_ctrl #(
  parameter int unsigned TableEntries = dtnu_pkg::TableEntries,
  parameter int unsigned IdxWidth     = (TableEntries > 1) ? $clog2(TableEntries) : 1,
  parameter int unsigned CntWidth     = $clog2(TableEntries + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  dtnu_pkg::req_t                 req_i,
  output logic                           rsp_valid_o,
  input  logic                           rsp_ready_i,
  output dtnu_pkg::rsp_t                 rsp_o,
  output logic                           mem_re_o,
  output logic [IdxWidth-1:0]            mem_raddr_o,
  input  logic [dtnu_pkg::AddrWidth-1:0] mem_rdata_i,
  output logic                           addr_we_o,
  output logic                           node_we_o,
  output logic [IdxWidth-1:0]            wr_idx_o,
  output logic [dtnu_pkg::AddrWidth-1:0] addr_wdata_o,
  output logic [dtnu_pkg::NodeWidth-1:0] node_wdata_o
);

  dtnu_pkg::state_e                 state_q, state_d;
  logic [dtnu_pkg::AddrWidth-1:0]   addr_q, addr_d;
  logic [dtnu_pkg::NodeWidth-1:0]   node_q, node_d;
  logic [CntWidth-1:0]              idx_q, idx_d;
  logic                             chk_vld_q, chk_vld_d;
  logic [IdxWidth-1:0]              chk_idx_q, chk_idx_d;
  logic                             free_vld_q, free_vld_d;
  logic [IdxWidth-1:0]              free_idx_q, free_idx_d;
  logic                             hit_q, hit_d;
  logic [IdxWidth-1:0]              hit_idx_q, hit_idx_d;
  logic [TableEntries-1:0]          valid_q, valid_d;
  logic                             rsp_valid_q, rsp_valid_d;
  dtnu_pkg::rsp_t                   rsp_q, rsp_d;
  logic                             match;
  logic [IdxWidth-1:0]              scan_idx;
  logic [IdxWidth-1:0]              wr_idx;
  logic [IdxWidth+dtnu_pkg::SlotWidth-1:0] slot_ext;

  assign scan_idx = idx_q[IdxWidth-1:0];
  assign match    = chk_vld_q && valid_q[chk_idx_q] && (mem_rdata_i == addr_q);
  assign wr_idx   = hit_q ? hit_idx_q : free_idx_q;
  assign slot_ext = {{dtnu_pkg::SlotWidth{1'b0}}, wr_idx};

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    node_d      = node_q;
    idx_d       = idx_q;
    chk_vld_d   = chk_vld_q;
    chk_idx_d   = chk_idx_q;
    free_vld_d  = free_vld_q;
    free_idx_d  = free_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    valid_d     = valid_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    req_ready_o = 1'b0;
    mem_re_o    = 1'b0;
    addr_we_o   = 1'b0;
    node_we_o   = 1'b0;

    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      dtnu_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          addr_d     = req_i.dev_address;
          node_d     = req_i.node_ident;
          idx_d      = '0;
          chk_vld_d  = 1'b0;
          free_vld_d = 1'b0;
          hit_d      = 1'b0;
          state_d    = dtnu_pkg::ST_SCAN;
        end
      end
      dtnu_pkg::ST_SCAN: begin
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = chk_idx_q;
          chk_vld_d = 1'b0;
          state_d   = dtnu_pkg::ST_WRITE;
        end else if (idx_q != CntWidth'(TableEntries)) begin
          mem_re_o  = valid_q[scan_idx];
          chk_vld_d = valid_q[scan_idx];
          chk_idx_d = scan_idx;
          idx_d     = idx_q + CntWidth'(1);
          if (!valid_q[scan_idx] && !free_vld_q) begin
            free_vld_d = 1'b1;
            free_idx_d = scan_idx;
          end
        end else begin
          chk_vld_d = 1'b0;
          state_d   = dtnu_pkg::ST_WRITE;
        end
      end
      dtnu_pkg::ST_WRITE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d = 1'b1;
          state_d     = dtnu_pkg::ST_IDLE;
          if (hit_q) begin
            node_we_o           = 1'b1;
            rsp_d.result_status = dtnu_pkg::STATUS_UPDATED;
            rsp_d.slot_index    = slot_ext[dtnu_pkg::SlotWidth-1:0];
          end else if (free_vld_q) begin
            node_we_o           = 1'b1;
            addr_we_o           = 1'b1;
            valid_d[free_idx_q] = 1'b1;
            rsp_d.result_status = dtnu_pkg::STATUS_INSERTED;
            rsp_d.slot_index    = slot_ext[dtnu_pkg::SlotWidth-1:0];
          end else begin
            rsp_d.result_status = dtnu_pkg::STATUS_FULL;
            rsp_d.slot_index    = '0;
          end
        end
      end
      default: begin
        state_d = dtnu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtnu_pkg::ST_IDLE;
      idx_q       <= '0;
      chk_vld_q   <= 1'b0;
      free_vld_q  <= 1'b0;
      hit_q       <= 1'b0;
      valid_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      chk_vld_q   <= chk_vld_d;
      free_vld_q  <= free_vld_d;
      hit_q       <= hit_d;
      valid_q     <= valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    node_q     <= node_d;
    chk_idx_q  <= chk_idx_d;
    free_idx_q <= free_idx_d;
    hit_idx_q  <= hit_idx_d;
    rsp_q      <= rsp_d;
  end

  assign mem_raddr_o  = scan_idx;
  assign wr_idx_o     = wr_idx;
  assign addr_wdata_o = addr_q;
  assign node_wdata_o = node_q;
  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_o        = rsp_q;

endmodule

// ===== hdl/device_to_node_table_update_core.sv =====
// top level of the device-to-node table update block
// Each request looks up its device address among the valid table slots; on a hit the
// slot's node identifier is overwritten, otherwise the pair goes into the lowest free
// slot, and with no free slot a full status comes back with slot index zero. One
// request is handled at a time: the address memory is read one slot per cycle through
// its single registered read port, and the scan ends early on a hit. The response sits
// in an output register and the block returns to idle as it is set, so the next request
// is accepted while it waits; the write step of a further request holds until that
// response is taken. Valid marks are cleared at reset; no clearing pass is needed.
module device_to_node_table_update_core #(
  parameter int unsigned TABLE_ENTRIES = dtnu_pkg::TableEntries
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  dtnu_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output dtnu_pkg::rsp_t rsp_o
);

  localparam int unsigned IdxWidth = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntWidth = $clog2(TABLE_ENTRIES + 1);

  logic                           mem_re;
  logic [IdxWidth-1:0]            mem_raddr;
  logic [dtnu_pkg::AddrWidth-1:0] mem_rdata;
  logic                           addr_we;
  logic                           node_we;
  logic [IdxWidth-1:0]            wr_idx;
  logic [dtnu_pkg::AddrWidth-1:0] addr_wdata;
  logic [dtnu_pkg::NodeWidth-1:0] node_wdata;

  dtnu_ctrl #(
    .TableEntries(TABLE_ENTRIES),
    .IdxWidth    (IdxWidth),
    .CntWidth    (CntWidth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .addr_we_o   (addr_we),
    .node_we_o   (node_we),
    .wr_idx_o    (wr_idx),
    .addr_wdata_o(addr_wdata),
    .node_wdata_o(node_wdata)
  );

  dtnu_addr_mem #(
    .Depth   (TABLE_ENTRIES),
    .Width   (dtnu_pkg::AddrWidth),
    .IdxWidth(IdxWidth)
  ) u_addr_mem (
    .clk_i  (clk_i),
    .we_i   (addr_we),
    .waddr_i(wr_idx),
    .wdata_i(addr_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  dtnu_node_mem #(
    .Depth   (TABLE_ENTRIES),
    .Width   (dtnu_pkg::NodeWidth),
    .IdxWidth(IdxWidth)
  ) u_node_mem (
    .clk_i  (clk_i),
    .we_i   (node_we),
    .waddr_i(wr_idx),
    .wdata_i(node_wdata)
  );

endmodule

// ===== sim/device_to_node_table_update_core_checker.sv =====
// watches both channels of the table update block, models the table and checks each response
module device_to_node_table_update_core_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_ready_i,
  input  dtnu_pkg::req_t req_i,
  input  logic           rsp_valid_i,
  input  logic           rsp_ready_i,
  input  dtnu_pkg::rsp_t rsp_i,
  output int             fail_count_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                           slot_used [dtnu_pkg::TableEntries];
  logic [dtnu_pkg::AddrWidth-1:0] slot_addr [dtnu_pkg::TableEntries];
  logic [dtnu_pkg::NodeWidth-1:0] slot_node [dtnu_pkg::TableEntries];
  dtnu_pkg::rsp_t                 awaited_rsps [$];
  dtnu_pkg::rsp_t                 oldest_rsp;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  function automatic dtnu_pkg::rsp_t apply_table_update(input dtnu_pkg::req_t r);
    dtnu_pkg::rsp_t res;
    res.result_status = dtnu_pkg::STATUS_FULL;
    res.slot_index    = '0;
    for (int k = 0; k < dtnu_pkg::TableEntries; k++) begin
      if (slot_used[k] && slot_addr[k] == r.dev_address) begin
        slot_node[k]      = r.node_ident;
        res.result_status = dtnu_pkg::STATUS_UPDATED;
        res.slot_index    = dtnu_pkg::SlotWidth'(k);
        return res;
      end
    end
    for (int k = 0; k < dtnu_pkg::TableEntries; k++) begin
      if (!slot_used[k]) begin
        slot_used[k]      = 1'b1;
        slot_addr[k]      = r.dev_address;
        slot_node[k]      = r.node_ident;
        res.result_status = dtnu_pkg::STATUS_INSERTED;
        res.slot_index    = dtnu_pkg::SlotWidth'(k);
        return res;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < dtnu_pkg::TableEntries; k++) slot_used[k] = 1'b0;
      awaited_rsps.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_rsps.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          oldest_rsp = awaited_rsps.pop_front();
          if (rsp_i.result_status !== oldest_rsp.result_status)
            report_mismatch($sformatf("result_status got %0d want %0d",
                                      rsp_i.result_status, oldest_rsp.result_status));
          if (rsp_i.slot_index !== oldest_rsp.slot_index)
            report_mismatch($sformatf("slot_index got %0d want %0d",
                                      rsp_i.slot_index, oldest_rsp.slot_index));
        end
      end
      if (req_valid_i && req_ready_i) awaited_rsps.push_back(apply_table_update(req_i));
      pending_o = awaited_rsps.size();
    end
  end

endmodule

// ===== sim/device_to_node_table_update_core_test.sv =====
// testbench top: drives requests and response stalls into the table update block, gives the verdict
module device_to_node_table_update_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           req_valid_i = 1'b0;
  logic           rsp_ready_i = 1'b0;
  dtnu_pkg::req_t req_i       = '0;
  logic           req_ready_o;
  logic           rsp_valid_o;
  dtnu_pkg::rsp_t rsp_o;
  int             fail_count;
  int             pending;
  int             idle_pct  = 0;
  int             stall_pct = 0;
  logic [31:0]    stored_addrs [$];

  always #10 clk_i = ~clk_i;

  device_to_node_table_update_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  device_to_node_table_update_core_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_i (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_i (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_i       (rsp_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(negedge clk_i) begin
    rsp_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_request(input logic [dtnu_pkg::AddrWidth-1:0] addr,
                              input logic [dtnu_pkg::NodeWidth-1:0] node);
    while ($urandom_range(99) < idle_pct) begin
      req_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= '{dev_address: addr, node_ident: node};
    do @(posedge clk_i); while (!req_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_all_responses();
    req_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic [dtnu_pkg::AddrWidth-1:0] addr;
    int                             pick;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fill the table, touching both address extremes first
    stored_addrs.push_back(32'h0000_0000);
    stored_addrs.push_back(32'hFFFF_FFFF);
    stored_addrs.push_back(32'hA5A5_A5A5);
    for (int i = 0; i < 13; i++) stored_addrs.push_back(32'h1 << (2 * i));
    send_request(32'h0000_0000, 64'h0);
    send_request(32'h0000_0000, {64{1'b1}});
    send_request(32'hFFFF_FFFF, {64{1'b1}});
    send_request(32'hFFFF_FFFF, 64'h0);
    send_request(32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);
    for (int i = 3; i < 16; i++) send_request(stored_addrs[i], {$urandom, $urandom});
    // table full for two new addresses, then updates to the last slot and to slot 8
    send_request(32'h1234_5678, {$urandom, $urandom});
    send_request(32'hFFFF_FFFE, {64{1'b1}});
    send_request(stored_addrs[15], 64'hA5A5_A5A5_A5A5_A5A5);
    send_request(stored_addrs[8], {$urandom, $urandom});

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      if (phase == 2) wait_all_responses();
      repeat (175) begin
        pick = $urandom_range(99);
        if (pick < 65)
          addr = stored_addrs[$urandom_range(stored_addrs.size() - 1)];
        else if (pick < 85)
          addr = $urandom;
        else
          addr = stored_addrs[$urandom_range(stored_addrs.size() - 1)] ^
                 (32'h1 << $urandom_range(31));
        send_request(addr, {$urandom, $urandom});
      end
    end

    req_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (dtnu_pkg::TableEntries + 8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("device_to_node_table_update_core_test passed");
    end else begin
      $display("device_to_node_table_update_core_test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("device_to_node_table_update_core_test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dtnu_pkg.sv
hdl/dtnu_addr_mem.sv
hdl/dtnu_node_mem.sv
hdl/dtnu_ctrl.sv
hdl/device_to_node_table_update_core.sv
sim/device_to_node_table_update_core_checker.sv
sim/device_to_node_table_update_core_test.sv
